>>> src/fixed_point_natural_log_defines.svh
// Assertion macros used by the checker file.
`ifndef FIXED_POINT_NATURAL_LOG_DEFINES_SVH
`define FIXED_POINT_NATURAL_LOG_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define FPLN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define FPLN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/fpln_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpln_pkg;

    // Fixed-point format and series length.
    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_TERMS  = 35;
    localparam int DIV_STEPS  = WORD_BITS + FRAC_BITS;
    localparam int CNT_BITS   = $clog2(DIV_STEPS);
    localparam int TERM_BITS  = $clog2(NUM_TERMS + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);

    localparam logic signed [WORD_BITS-1:0] ONE = WORD_BITS'(1 << FRAC_BITS);

    // Horner ratios (2k-1)/(2k+1), floored to the fraction bits; entry 0 is unused.
    localparam logic signed [WORD_BITS-1:0] COEF [0:NUM_TERMS] = '{
        '0,
        WORD_BITS'( 1 * 65536 /  3), WORD_BITS'( 3 * 65536 /  5),
        WORD_BITS'( 5 * 65536 /  7), WORD_BITS'( 7 * 65536 /  9),
        WORD_BITS'( 9 * 65536 / 11), WORD_BITS'(11 * 65536 / 13),
        WORD_BITS'(13 * 65536 / 15), WORD_BITS'(15 * 65536 / 17),
        WORD_BITS'(17 * 65536 / 19), WORD_BITS'(19 * 65536 / 21),
        WORD_BITS'(21 * 65536 / 23), WORD_BITS'(23 * 65536 / 25),
        WORD_BITS'(25 * 65536 / 27), WORD_BITS'(27 * 65536 / 29),
        WORD_BITS'(29 * 65536 / 31), WORD_BITS'(31 * 65536 / 33),
        WORD_BITS'(33 * 65536 / 35), WORD_BITS'(35 * 65536 / 37),
        WORD_BITS'(37 * 65536 / 39), WORD_BITS'(39 * 65536 / 41),
        WORD_BITS'(41 * 65536 / 43), WORD_BITS'(43 * 65536 / 45),
        WORD_BITS'(45 * 65536 / 47), WORD_BITS'(47 * 65536 / 49),
        WORD_BITS'(49 * 65536 / 51), WORD_BITS'(51 * 65536 / 53),
        WORD_BITS'(53 * 65536 / 55), WORD_BITS'(55 * 65536 / 57),
        WORD_BITS'(57 * 65536 / 59), WORD_BITS'(59 * 65536 / 61),
        WORD_BITS'(61 * 65536 / 63), WORD_BITS'(63 * 65536 / 65),
        WORD_BITS'(65 * 65536 / 67), WORD_BITS'(67 * 65536 / 69),
        WORD_BITS'(69 * 65536 / 71)
    };

    // One classified sample as it waits in the queue.
    typedef struct packed {
        logic signed [31:0] current;
        logic signed [31:0] voltage;
        logic               domain_error;
    } sample_t;

    // Write request from the front end to the queue.
    typedef struct packed {
        logic    push;
        sample_t data;
    } q_push_t;

    // Read side of the queue as the back end sees it.
    typedef struct packed {
        logic    empty;
        sample_t data;
    } q_head_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_XFIX,
        ST_SQ,
        ST_TOP,
        ST_MA,
        ST_MB,
        ST_FIN,
        ST_DONE
    } core_state_t;

endpackage

`default_nettype wire

>>> src/fpln_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fpln_front (
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [63:0]      s_axis_tdata,   // current_code, voltage_code
    input  wire logic             q_full,
    output fpln_pkg::q_push_t     q_push
);
    import fpln_pkg::*;

    logic signed [31:0] current;

    // Accept a beat whenever the queue has room.
    assign s_axis_tready = !q_full;
    assign current       = s_axis_tdata[31:0];

    // Classify the sample: a current at or below zero has no log.
    always_comb
    begin
        q_push.push              = s_axis_tvalid && !q_full;
        q_push.data.current      = current;
        q_push.data.voltage      = s_axis_tdata[63:32];
        q_push.data.domain_error = (current <= 0);
    end

endmodule

`default_nettype wire

>>> src/fpln_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module fpln_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire fpln_pkg::q_push_t  q_push,
    output logic                    q_full,
    input  wire logic               pop,
    output fpln_pkg::q_head_t       q_head
);
    import fpln_pkg::*;

    sample_t                mem [0:FIFO_DEPTH-1];
    logic [PTR_BITS-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PTR_BITS:0]      count_reg, count_next;

    assign q_full       = (count_reg == (PTR_BITS+1)'(FIFO_DEPTH));
    assign q_head.empty = (count_reg == '0);
    assign q_head.data  = mem[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (q_push.push && !(pop && !q_head.empty))
            count_next = count_reg + 1'b1;
        else if (!q_push.push && pop && !q_head.empty)
            count_next = count_reg - 1'b1;
    end

    // Pointer and count registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (q_push.push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop && !q_head.empty)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (q_push.push)
            mem[wr_ptr_reg] <= q_push.data;
    end

endmodule

`default_nettype wire

>>> src/fpln_core.sv
`timescale 1ns / 1ps
`default_nettype none

module fpln_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fpln_pkg::q_head_t q_head,
    output logic                   pop,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [63:0]            m_axis_tdata,   // log_value, voltage_out
    output logic [0:0]             m_axis_tuser    // domain_error
);
    import fpln_pkg::*;

    core_state_t                   state_reg, state_next;
    logic [DIV_STEPS-1:0]          dvd_reg, dvd_next;
    logic [WORD_BITS-1:0]          rem_reg, rem_next;
    logic [WORD_BITS-1:0]          ad_reg, ad_next;
    logic [WORD_BITS-1:0]          q_reg, q_next;
    logic                          sn_reg, sn_next, sd_reg, sd_next;
    logic [CNT_BITS-1:0]           cnt_reg, cnt_next;
    logic [TERM_BITS-1:0]          k_reg, k_next;
    logic signed [WORD_BITS-1:0]   x_reg, x_next, k2_reg, k2_next;
    logic signed [WORD_BITS-1:0]   aux_reg, aux_next, t_reg, t_next;
    logic signed [WORD_BITS-1:0]   res_reg, res_next;
    logic signed [31:0]            volt_reg, volt_next;
    logic                          derr_reg, derr_next;
    logic                          out_valid_reg, out_valid_next;
    logic [31:0]                   out_log_reg, out_log_next;
    logic [31:0]                   out_volt_reg, out_volt_next;
    logic                          out_derr_reg, out_derr_next;

    logic signed [WORD_BITS-1:0]   mul_a, mul_b, prod_w;
    logic signed [2*WORD_BITS-1:0] prod;
    logic signed [WORD_BITS-1:0]   num, den;
    logic [WORD_BITS:0]            r2;
    logic                          ge;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_volt_reg, out_log_reg};
    assign m_axis_tuser  = out_derr_reg;

    // Shared multiplier, floored to the fraction bits and wrapped to a word.
    always_comb
    begin
        mul_a = aux_reg;
        mul_b = COEF[k_reg];
        unique case (state_reg)
            ST_SQ:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            ST_TOP:
            begin
                mul_a = k2_reg;
                mul_b = COEF[NUM_TERMS];
            end
            ST_MB:
            begin
                mul_a = t_reg;
                mul_b = k2_reg;
            end
            ST_FIN:
            begin
                mul_a = aux_reg;
                mul_b = x_reg;
            end
            default:
            begin
                mul_a = aux_reg;
                mul_b = COEF[k_reg];
            end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign prod_w = prod[FRAC_BITS +: WORD_BITS];

    // One restoring division step per cycle.
    assign r2 = {rem_reg, dvd_reg[DIV_STEPS-1]};
    assign ge = (r2 >= {1'b0, ad_reg});

    // Operands of the quotient (i - 1) / (i + 1).
    assign num = q_head.data.current - ONE;
    assign den = q_head.data.current + ONE;

    // Sequencer: divide, square, Horner chain, final product, hand-off; a domain error goes straight to hand-off.
    always_comb
    begin
        state_next     = state_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        ad_next        = ad_reg;
        q_next         = q_reg;
        sn_next        = sn_reg;
        sd_next        = sd_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        x_next         = x_reg;
        k2_next        = k2_reg;
        aux_next       = aux_reg;
        t_next         = t_reg;
        res_next       = res_reg;
        volt_next      = volt_reg;
        derr_next      = derr_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_log_next   = out_log_reg;
        out_volt_next  = out_volt_reg;
        out_derr_next  = out_derr_reg;
        pop            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_head.empty)
                begin
                    pop       = 1'b1;
                    volt_next = q_head.data.voltage;
                    derr_next = q_head.data.domain_error;
                    sn_next   = num[WORD_BITS-1];
                    sd_next   = den[WORD_BITS-1];
                    ad_next   = den[WORD_BITS-1] ? WORD_BITS'(-den) : den;
                    dvd_next  = {(num[WORD_BITS-1] ? WORD_BITS'(-num) : num),
                                 {FRAC_BITS{1'b0}}};
                    rem_next  = '0;
                    q_next    = '0;
                    cnt_next  = CNT_BITS'(DIV_STEPS - 1);
                    res_next  = '0;
                    state_next = q_head.data.domain_error ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? WORD_BITS'(r2 - {1'b0, ad_reg}) : r2[WORD_BITS-1:0];
                q_next   = {q_reg[WORD_BITS-2:0], ge};
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_XFIX;
            end
            ST_XFIX:
            begin
                // Signs differ: floor the quotient; a zero divisor gives zero.
                if (ad_reg == '0)
                    x_next = '0;
                else if (sn_reg != sd_reg)
                    x_next = (rem_reg != '0) ? ~q_reg : -q_reg;
                else
                    x_next = q_reg;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                k2_next    = prod_w;
                state_next = ST_TOP;
            end
            ST_TOP:
            begin
                aux_next   = prod_w + ONE;
                k_next     = TERM_BITS'(NUM_TERMS - 1);
                state_next = ST_MA;
            end
            ST_MA:
            begin
                t_next     = prod_w;
                state_next = ST_MB;
            end
            ST_MB:
            begin
                aux_next = prod_w + ONE;
                if (k_reg == TERM_BITS'(1))
                    state_next = ST_FIN;
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = ST_MA;
                end
            end
            ST_FIN:
            begin
                res_next   = prod_w << 1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_log_next   = res_reg[31:0];
                    out_volt_next  = volt_reg;
                    out_derr_next  = derr_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        ad_reg       <= ad_next;
        q_reg        <= q_next;
        sn_reg       <= sn_next;
        sd_reg       <= sd_next;
        cnt_reg      <= cnt_next;
        k_reg        <= k_next;
        x_reg        <= x_next;
        k2_reg       <= k2_next;
        aux_reg      <= aux_next;
        t_reg        <= t_next;
        res_reg      <= res_next;
        volt_reg     <= volt_next;
        derr_reg     <= derr_next;
        out_log_reg  <= out_log_next;
        out_volt_reg <= out_volt_next;
        out_derr_reg <= out_derr_next;
    end

endmodule

`default_nettype wire

>>> src/fixed_point_natural_log.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  tdata (low bit up)             tuser
// s_axis    in         current_code, voltage_code     -
// m_axis    out        log_value, voltage_out         domain_error
//
// In the back end a valid sample passes through the bit-serial divider, a
// quotient fix-up and the shared 32x32 multiplier over the Horner chain.
// A sample with a non-positive current skips these and goes to the hand-off.
// A four-entry queue takes input beats while the back end works.
// Reset is asynchronous and active low; it empties the queue and the output.
// A stalled output holds its beat; the back end waits until it is taken.

module fixed_point_natural_log (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // current_code, voltage_code
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // log_value, voltage_out
    output logic [0:0]       m_axis_tuser    // domain_error
);
    import fpln_pkg::*;

    q_push_t q_push;
    q_head_t q_head;
    logic    q_full;
    logic    pop;

    // Front end: accept and classify.
    fpln_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push)
    );

    // Queue between the two halves.
    fpln_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_full (q_full),
        .pop    (pop),
        .q_head (q_head)
    );

    // Back end: divider, multiplier sequencer and output register.
    fpln_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_head        (q_head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

>>> src/fpln_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_point_natural_log_defines.svh"

module fpln_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [63:0] s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);

    // A stalled output beat stays put.
    `FPLN_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output beat changed while stalled")

    // A domain error always carries a zero log.
    `FPLN_ASSERT_NOW(a_derr_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[31:0] == 32'd0, "domain error with nonzero log")

    // The queue cannot fill up without a push.
    `FPLN_ASSERT_NEXT(a_ready_keep, s_axis_tready && !s_axis_tvalid, s_axis_tready, "input ready dropped without a beat")

endmodule

bind fixed_point_natural_log fpln_checker u_chk (.*);

`default_nettype wire
